/* hw/rtl/udlc_pkg.sv */
// ----------------------------------------------------------------------------
// udlc_pkg
// Types, character codes and header prefix tables for the diff line classifier.
// ----------------------------------------------------------------------------
package udlc_pkg;

  // One input word: a byte of diff text and the last-byte mark.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  // One result word, delivered when a classified line closes.
  typedef struct packed {
    logic [1:0]  line_kind;
    logic [31:0] old_number;
    logic [31:0] new_number;
    logic [31:0] added_total;
    logic [31:0] removed_total;
    logic [31:0] modified_total;
    logic [31:0] context_total;
    logic        text_done;
  } out_word_t;

  typedef enum logic [1:0] {
    KIND_CONTEXT  = 2'd0,
    KIND_ADDED    = 2'd1,
    KIND_REMOVED  = 2'd2,
    KIND_MODIFIED = 2'd3
  } kind_t;

  // Hunk header recognizer phases for "@@ -A[,n] +B[,m]".
  typedef enum logic [3:0] {
    HP_AT0    = 4'd0,
    HP_AT1    = 4'd1,
    HP_SP     = 4'd2,
    HP_OLD0   = 4'd3,
    HP_OLD    = 4'd4,
    HP_OLDCNT = 4'd5,
    HP_SP2    = 4'd6,
    HP_NEW0   = 4'd7,
    HP_NEW    = 4'd8,
    HP_NEWCNT = 4'd9,
    HP_VALID  = 4'd10,
    HP_FAIL   = 4'd11
  } hunk_phase_t;

  localparam int NPFX       = 13;
  localparam int PFX_MAXLEN = 18;
  localparam logic [4:0] POS_MAX = 5'd31;

  // Per-line scan state that does not depend on the number width.
  typedef struct packed {
    logic [4:0]      pos;
    logic [7:0]      first;
    logic [NPFX-1:0] alive;
    hunk_phase_t     phase;
  } line_ctl_t;

  localparam line_ctl_t LINE_CLEAR = '{pos: 5'd0, first: 8'd0, alive: '1, phase: HP_AT0};

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Header prefixes, left aligned and padded with zero bytes to the longest one.
  localparam logic [8*PFX_MAXLEN-1:0] PFX_TEXT [NPFX] = '{
    {"--- ", {14{8'h00}}},
    {"+++ ", {14{8'h00}}},
    {"diff ", {13{8'h00}}},
    {"index ", {12{8'h00}}},
    {"old mode ", {9{8'h00}}},
    {"new mode ", {9{8'h00}}},
    {"new file mode ", {4{8'h00}}},
    "deleted file mode ",
    {"similarity index ", {1{8'h00}}},
    {"rename ", {11{8'h00}}},
    {"copy ", {13{8'h00}}},
    {"Binary files ", {5{8'h00}}},
    {"\\", {17{8'h00}}}
  };

  localparam logic [4:0] PFX_LEN [NPFX] = '{
    5'd4, 5'd4, 5'd5, 5'd6, 5'd9, 5'd9, 5'd14, 5'd18, 5'd17, 5'd7, 5'd5, 5'd13, 5'd1
  };

  // Character at position pos of prefix idx; positions past the table clamp.
  function automatic logic [7:0] pfx_char(input logic [3:0] idx, input logic [4:0] pos);
    logic [4:0] p;
    p = (pos > 5'(PFX_MAXLEN - 1)) ? 5'(PFX_MAXLEN - 1) : pos;
    return PFX_TEXT[idx][8*(PFX_MAXLEN - 1 - int'(p)) +: 8];
  endfunction

endpackage

/* hw/rtl/udlc_scan.sv */
// ----------------------------------------------------------------------------
// udlc_scan
// Feeds one content byte into the line scan state: prefix match, hunk parse.
// ----------------------------------------------------------------------------
module udlc_scan #(
  parameter int LINE_BITS = 32
) (
  input  udlc_pkg::line_ctl_t   ctl_i,
  input  logic [7:0]            byte_i,
  input  logic [LINE_BITS-1:0]  old_val_i,
  input  logic [LINE_BITS-1:0]  new_val_i,
  output udlc_pkg::line_ctl_t   ctl_o,
  output logic [LINE_BITS-1:0]  old_val_o,
  output logic [LINE_BITS-1:0]  new_val_o
);
  import udlc_pkg::*;

  // Decimal accumulate with saturation at all ones.
  function automatic logic [LINE_BITS-1:0] dec_acc(input logic [LINE_BITS-1:0] v,
                                                   input logic [3:0] d);
    logic [LINE_BITS+3:0] w;
    w = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + (LINE_BITS+4)'(d);
    return (w[LINE_BITS+3:LINE_BITS] != 4'd0) ? '1 : w[LINE_BITS-1:0];
  endfunction

  logic dig;

  always_comb begin
    ctl_o     = ctl_i;
    old_val_o = old_val_i;
    new_val_o = new_val_i;
    dig       = byte_i inside {[8'h30:8'h39]};

    if (ctl_i.pos == 5'd0) begin
      ctl_o.first = byte_i;
    end
    for (int i = 0; i < NPFX; i++) begin
      if (ctl_i.pos < PFX_LEN[i] && byte_i != pfx_char(4'(i), ctl_i.pos)) begin
        ctl_o.alive[i] = 1'b0;
      end
    end

    case (ctl_i.phase)
      HP_AT0: ctl_o.phase = (byte_i == CH_AT) ? HP_AT1 : HP_FAIL;
      HP_AT1: ctl_o.phase = (byte_i == CH_AT) ? HP_SP : HP_FAIL;
      HP_SP: begin
        if (byte_i == CH_SPACE)      ctl_o.phase = HP_SP;
        else if (byte_i == CH_MINUS) ctl_o.phase = HP_OLD0;
        else                         ctl_o.phase = HP_FAIL;
      end
      HP_OLD0: begin
        if (dig) begin
          old_val_o   = dec_acc(old_val_i, byte_i[3:0]);
          ctl_o.phase = HP_OLD;
        end else begin
          ctl_o.phase = HP_FAIL;
        end
      end
      HP_OLD: begin
        if (dig)                     old_val_o   = dec_acc(old_val_i, byte_i[3:0]);
        else if (byte_i == CH_COMMA) ctl_o.phase = HP_OLDCNT;
        else if (byte_i == CH_SPACE) ctl_o.phase = HP_SP2;
        else if (byte_i == CH_PLUS)  ctl_o.phase = HP_NEW0;
        else                         ctl_o.phase = HP_FAIL;
      end
      HP_OLDCNT: begin
        if (dig)                     ctl_o.phase = HP_OLDCNT;
        else if (byte_i == CH_SPACE) ctl_o.phase = HP_SP2;
        else if (byte_i == CH_PLUS)  ctl_o.phase = HP_NEW0;
        else                         ctl_o.phase = HP_FAIL;
      end
      HP_SP2: begin
        if (byte_i == CH_SPACE)     ctl_o.phase = HP_SP2;
        else if (byte_i == CH_PLUS) ctl_o.phase = HP_NEW0;
        else                        ctl_o.phase = HP_FAIL;
      end
      HP_NEW0: begin
        if (dig) begin
          new_val_o   = dec_acc(new_val_i, byte_i[3:0]);
          ctl_o.phase = HP_NEW;
        end else begin
          ctl_o.phase = HP_FAIL;
        end
      end
      HP_NEW: begin
        if (dig)                     new_val_o   = dec_acc(new_val_i, byte_i[3:0]);
        else if (byte_i == CH_COMMA) ctl_o.phase = HP_NEWCNT;
        else                         ctl_o.phase = HP_VALID;
      end
      HP_NEWCNT: ctl_o.phase = dig ? HP_NEWCNT : HP_VALID;
      HP_VALID:  ctl_o.phase = HP_VALID;
      default:   ctl_o.phase = HP_FAIL;
    endcase

    if (ctl_i.pos != POS_MAX) begin
      ctl_o.pos = ctl_i.pos + 5'd1;
    end
  end

endmodule

/* hw/rtl/unified_diff_line_classifier_top.sv */
// ----------------------------------------------------------------------------
// unified_diff_line_classifier_top
// Classifies unified-diff text lines from a byte stream and keeps line counts.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Word           Direction
//   input    in_valid in_ready in_data      in_word_t      into the block
//   result   out_valid out_ready out_data   out_word_t     out of the block
//
// Each byte is taken into an input register and handled, once the result
// register is free or being emptied, by one pass of logic that updates the
// line state and fills the result register. A new byte can be taken every
// cycle, so the sustained rate is one byte per cycle; it falls below that only
// while a result waits in the result register and out_ready is low. Reset is
// synchronous and active low; it clears the line state, the kind counts and
// both valid flags, and sets the line-number counters to one.
module unified_diff_line_classifier_top #(
  parameter int LINE_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  udlc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output udlc_pkg::out_word_t  out_data
);
  import udlc_pkg::*;

  // Input register.
  logic     in_vld_r, in_vld_nxt;
  in_word_t in_q_r;

  // Line scan state and per-text counters.
  line_ctl_t              ctl_r, ctl_nxt;
  logic                   held_cr_r, held_cr_nxt;
  logic [LINE_BITS-1:0]   hold_old_r, hold_old_nxt;
  logic [LINE_BITS-1:0]   hold_new_r, hold_new_nxt;
  logic [LINE_BITS-1:0]   old_ctr_r, old_ctr_nxt;
  logic [LINE_BITS-1:0]   new_ctr_r, new_ctr_nxt;
  logic [COUNT_BITS-1:0]  cnt_r [4];
  logic [COUNT_BITS-1:0]  cnt_nxt [4];

  // Result register.
  logic      out_vld_r, out_vld_nxt;
  out_word_t out_q_r, out_q_nxt;

  // The byte in the input register is handled when the result register is free
  // or is being emptied in this cycle.
  logic proc;
  assign proc     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || !out_vld_r || out_ready;

  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  // A CR held from the previous byte turns out to be content when a byte other
  // than LF follows, so it is fed first, then the current byte.
  line_ctl_t            ctl_a, ctl_b_in, ctl_b;
  logic [LINE_BITS-1:0] old_a, new_a, old_b_in, new_b_in, old_b, new_b;

  udlc_scan #(.LINE_BITS(LINE_BITS)) u_scan_cr (
    .ctl_i     (ctl_r),
    .byte_i    (CH_CR),
    .old_val_i (hold_old_r),
    .new_val_i (hold_new_r),
    .ctl_o     (ctl_a),
    .old_val_o (old_a),
    .new_val_o (new_a)
  );

  assign ctl_b_in = held_cr_r ? ctl_a : ctl_r;
  assign old_b_in = held_cr_r ? old_a : hold_old_r;
  assign new_b_in = held_cr_r ? new_a : hold_new_r;

  udlc_scan #(.LINE_BITS(LINE_BITS)) u_scan_byte (
    .ctl_i     (ctl_b_in),
    .byte_i    (in_q_r.text_byte),
    .old_val_i (old_b_in),
    .new_val_i (new_b_in),
    .ctl_o     (ctl_b),
    .old_val_o (old_b),
    .new_val_o (new_b)
  );

  logic                 is_lf, is_cr, eot, closing;
  line_ctl_t            fed_ctl, cls_ctl;
  logic [LINE_BITS-1:0] fed_old, fed_new, cls_old, cls_new;
  logic                 hunk_ok, header, has_kind;
  kind_t                kind;
  logic [LINE_BITS-1:0] old_num, new_num;

  always_comb begin
    is_lf   = (in_q_r.text_byte == CH_LF);
    is_cr   = (in_q_r.text_byte == CH_CR);
    eot     = in_q_r.end_of_text;
    closing = is_lf || eot;

    // State after feeding a non-LF byte; a CR is only held, not fed.
    fed_ctl = is_cr ? ctl_b_in : ctl_b;
    fed_old = is_cr ? old_b_in : old_b;
    fed_new = is_cr ? new_b_in : new_b;

    // An LF closes the line as it stands; a last byte that is not LF is fed first, unless it is a CR.
    cls_ctl = is_lf ? ctl_r      : fed_ctl;
    cls_old = is_lf ? hold_old_r : fed_old;
    cls_new = is_lf ? hold_new_r : fed_new;

    hunk_ok = (cls_ctl.phase == HP_NEW) || (cls_ctl.phase == HP_NEWCNT) ||
              (cls_ctl.phase == HP_VALID);

    // Exactly "---" or "+++" counts as a header, as does any completed prefix.
    header = (cls_ctl.pos == 5'd3) && (cls_ctl.alive[1:0] != 2'b00);
    for (int i = 0; i < NPFX; i++) begin
      if (cls_ctl.alive[i] && cls_ctl.pos >= PFX_LEN[i]) begin
        header = 1'b1;
      end
    end

    has_kind = 1'b0;
    kind     = KIND_CONTEXT;
    if (closing && !hunk_ok && !header) begin
      if (cls_ctl.pos == 5'd0 || cls_ctl.first == CH_SPACE) begin
        has_kind = 1'b1;
        kind     = KIND_CONTEXT;
      end else if (cls_ctl.first == CH_PLUS) begin
        has_kind = 1'b1;
        kind     = KIND_ADDED;
      end else if (cls_ctl.first == CH_MINUS) begin
        has_kind = 1'b1;
        kind     = KIND_REMOVED;
      end else if (cls_ctl.first == CH_TILDE) begin
        has_kind = 1'b1;
        kind     = KIND_MODIFIED;
      end
    end

    // Counters: a hunk header loads them, a classified line steps them.
    old_ctr_nxt = old_ctr_r;
    new_ctr_nxt = new_ctr_r;
    old_num     = '0;
    new_num     = '0;
    for (int i = 0; i < 4; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (closing && hunk_ok) begin
      old_ctr_nxt = (cls_old == '0) ? LINE_BITS'(1) : cls_old;
      new_ctr_nxt = (cls_new == '0) ? LINE_BITS'(1) : cls_new;
    end else if (has_kind) begin
      if (kind != KIND_ADDED) begin
        old_num     = old_ctr_r;
        old_ctr_nxt = (old_ctr_r == '1) ? old_ctr_r : old_ctr_r + LINE_BITS'(1);
      end
      if (kind != KIND_REMOVED) begin
        new_num     = new_ctr_r;
        new_ctr_nxt = (new_ctr_r == '1) ? new_ctr_r : new_ctr_r + LINE_BITS'(1);
      end
      for (int i = 0; i < 4; i++) begin
        if (kind == kind_t'(i) && cnt_r[i] != '1) begin
          cnt_nxt[i] = cnt_r[i] + COUNT_BITS'(1);
        end
      end
    end

    out_q_nxt.line_kind      = kind;
    out_q_nxt.old_number     = 32'(old_num);
    out_q_nxt.new_number     = 32'(new_num);
    out_q_nxt.added_total    = 32'(cnt_nxt[KIND_ADDED]);
    out_q_nxt.removed_total  = 32'(cnt_nxt[KIND_REMOVED]);
    out_q_nxt.modified_total = 32'(cnt_nxt[KIND_MODIFIED]);
    out_q_nxt.context_total  = 32'(cnt_nxt[KIND_CONTEXT]);
    out_q_nxt.text_done      = eot;

    // Line state: closed lines start over, the last byte restores everything.
    if (closing) begin
      ctl_nxt      = LINE_CLEAR;
      held_cr_nxt  = 1'b0;
      hold_old_nxt = '0;
      hold_new_nxt = '0;
    end else begin
      ctl_nxt      = fed_ctl;
      held_cr_nxt  = is_cr;
      hold_old_nxt = fed_old;
      hold_new_nxt = fed_new;
    end
    if (eot) begin
      old_ctr_nxt = LINE_BITS'(1);
      new_ctr_nxt = LINE_BITS'(1);
      for (int i = 0; i < 4; i++) begin
        cnt_nxt[i] = '0;
      end
    end

    // Handshake bookkeeping.
    if (in_valid && in_ready)  in_vld_nxt = 1'b1;
    else if (proc)             in_vld_nxt = 1'b0;
    else                       in_vld_nxt = in_vld_r;

    if (proc)           out_vld_nxt = has_kind;
    else if (out_ready) out_vld_nxt = 1'b0;
    else                out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      ctl_r      <= LINE_CLEAR;
      held_cr_r  <= 1'b0;
      hold_old_r <= '0;
      hold_new_r <= '0;
      old_ctr_r  <= LINE_BITS'(1);
      new_ctr_r  <= LINE_BITS'(1);
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (proc) begin
        ctl_r      <= ctl_nxt;
        held_cr_r  <= held_cr_nxt;
        hold_old_r <= hold_old_nxt;
        hold_new_r <= hold_new_nxt;
        old_ctr_r  <= old_ctr_nxt;
        new_ctr_r  <= new_ctr_nxt;
        for (int i = 0; i < 4; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
    if (proc && has_kind) begin
      out_q_r <= out_q_nxt;
    end
  end

  // An added line carries no old-file number.
  a_added_no_old: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_q_r.line_kind == KIND_ADDED |-> out_q_r.old_number == 32'd0)
    else $error("added line with nonzero old number");

  // A removed line carries no new-file number.
  a_removed_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_q_r.line_kind == KIND_REMOVED |-> out_q_r.new_number == 32'd0)
    else $error("removed line with nonzero new number");

  // The input side stalls only behind a result that is not being taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && out_vld_r && !out_ready)
    else $error("input stalled without a blocked result");

  // The last byte of a text leaves the counters and line state at reset values.
  a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_q_r.end_of_text |=>
      old_ctr_r == LINE_BITS'(1) && new_ctr_r == LINE_BITS'(1) &&
      cnt_r[0] == '0 && !held_cr_r && ctl_r == LINE_CLEAR)
    else $error("state not restored after end of text");

endmodule
